### hdl/lrps_pkg.sv
// Shared types and constants for the light refinement priority select block.
package lrps_pkg;

  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MAX_Z = 3'd5;

  // Light states
  localparam logic [1:0] ST_DISCARDED = 2'd0;
  localparam logic [1:0] ST_PARTIAL   = 2'd1;
  localparam logic [1:0] ST_NEW       = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         light_state;
    logic [31:0]        contribution;
    logic [31:0]        eye_distance;
    logic [31:0]        lit_stamp;
    logic [4:0]         refine_stage;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_light;
  } in_beat_t;

  typedef struct packed {
    logic       found;
    logic [7:0] best_index;
  } out_beat_t;

  // Fields that enter the priority rule
  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] contribution;
    logic [31:0] distance;
    logic [31:0] stamp;
    logic [4:0]  stage;
    logic        high;
  } prio_rec_t;

endpackage

### hdl/lrps_cmp.sv
// Priority rule: is the current best strictly lower priority than the candidate.
module lrps_cmp (
  input  lrps_pkg::prio_rec_t best,
  input  lrps_pkg::prio_rec_t cand,
  output logic                lower
);

  logic       a_zero;
  logic       b_zero;
  logic       stage_near;
  logic [5:0] a_stage;
  logic [5:0] b_stage;

  assign a_zero  = (best.contribution == 32'd0);
  assign b_zero  = (cand.contribution == 32'd0);
  assign a_stage = {1'b0, best.stage};
  assign b_stage = {1'b0, cand.stage};
  // stages within one of each other
  assign stage_near = (a_stage == b_stage) || (a_stage == b_stage + 6'd1) ||
                      (b_stage == a_stage + 6'd1);

  always_comb begin
    lower = 1'b0;
    priority if (best.high && !cand.high) begin
      lower = 1'b0;
    end else if (cand.high && !best.high) begin
      lower = 1'b1;
    end else begin
      unique case ({best.state, cand.state})
        {lrps_pkg::ST_NEW, lrps_pkg::ST_NEW}: begin
          lower = best.distance > cand.distance;
        end
        {lrps_pkg::ST_NEW, lrps_pkg::ST_DISCARDED}: begin
          lower = !b_zero;
        end
        {lrps_pkg::ST_NEW, lrps_pkg::ST_PARTIAL}: begin
          lower = 1'b0;
        end
        {lrps_pkg::ST_PARTIAL, lrps_pkg::ST_NEW}: begin
          lower = 1'b1;
        end
        {lrps_pkg::ST_DISCARDED, lrps_pkg::ST_NEW}: begin
          lower = a_zero;
        end
        {lrps_pkg::ST_PARTIAL, lrps_pkg::ST_PARTIAL}: begin
          priority if (a_zero && b_zero && (cand.stamp > best.stamp)) begin
            lower = 1'b1;
          end else if (b_zero && !a_zero) begin
            lower = 1'b0;
          end else if (a_zero && !b_zero) begin
            lower = 1'b1;
          end else if (stage_near) begin
            lower = best.contribution < cand.contribution;
          end else begin
            lower = best.stage > cand.stage;
          end
        end
        {lrps_pkg::ST_PARTIAL, lrps_pkg::ST_DISCARDED}: begin
          priority if (!b_zero) begin
            lower = 1'b1;
          end else if (a_zero) begin
            lower = cand.stamp > best.stamp;
          end else begin
            lower = best.contribution < cand.contribution;
          end
        end
        {lrps_pkg::ST_DISCARDED, lrps_pkg::ST_PARTIAL}: begin
          priority if (!a_zero) begin
            lower = 1'b0;
          end else if (b_zero) begin
            lower = cand.stamp > best.stamp;
          end else begin
            lower = best.contribution < cand.contribution;
          end
        end
        {lrps_pkg::ST_DISCARDED, lrps_pkg::ST_DISCARDED}: begin
          if (a_zero && b_zero) begin
            lower = cand.stamp > best.stamp;
          end else begin
            lower = best.contribution < cand.contribution;
          end
        end
        default: begin
          lower = 1'b0;
        end
      endcase
    end
  end

endmodule

### hdl/light_refinement_priority_select.sv
// Top level of the light refinement priority select block.
//
// Usage: one beat on the input channel per light record of a list. The
// block keeps the best light of the list so far and, on the beat marked
// last_light, emits one output beat: found and best_index (0 if no light
// other than a full one was seen). Full lights only advance the position.
// Channels use valid/stall; a beat moves when valid is high and stall low.
// Order: an input beat is registered, then compared against the running
// best in the next cycle; out_valid for a last record is set as that record
// leaves the input stage, held back while an earlier result still waits under stall.
// Throughput: one record per cycle, set by the single compare/update stage.
// While the output beat waits under stall, non-last records keep flowing;
// only a further last record holds the input stage (and so in_stall).
// Reset clears the best, the position counter, all three valid flags and the
// view box registers. The user writes the view box through cfg_we/cfg_index/
// cfg_data while the block is idle; the block itself does not enforce this. Indexes past the sixth are ignored.
module light_refinement_priority_select #(
  parameter int unsigned MAX_LIGHTS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lrps_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lrps_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [lrps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrps_pkg::CFG_W-1:0]          cfg_data
);

  localparam int unsigned CW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_LIGHTS - 1);

  // view box
  logic signed [31:0] view_min_x, view_min_y, view_min_z;
  logic signed [31:0] view_max_x, view_max_y, view_max_z;

  // input stage
  logic               a_valid;
  lrps_pkg::in_beat_t a;
  logic               advance;

  // running best
  logic                best_valid;
  logic [CW-1:0]       best_slot;
  lrps_pkg::prio_rec_t best;
  logic [CW-1:0]       item_count;

  lrps_pkg::prio_rec_t cand;
  logic                cand_high;
  logic                lower;
  logic                take;
  logic                found_next;
  logic [CW-1:0]       slot_next;
  logic [CW+7:0]       slot_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_min_x <= '0;
      view_min_y <= '0;
      view_min_z <= '0;
      view_max_x <= '0;
      view_max_y <= '0;
      view_max_z <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrps_pkg::CFG_VIEW_MIN_X: view_min_x <= $signed(cfg_data);
        lrps_pkg::CFG_VIEW_MIN_Y: view_min_y <= $signed(cfg_data);
        lrps_pkg::CFG_VIEW_MIN_Z: view_min_z <= $signed(cfg_data);
        lrps_pkg::CFG_VIEW_MAX_X: view_max_x <= $signed(cfg_data);
        lrps_pkg::CFG_VIEW_MAX_Y: view_max_y <= $signed(cfg_data);
        lrps_pkg::CFG_VIEW_MAX_Z: view_max_z <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Input stage moves on unless it holds a last record and the output
  // register is still full and stalled.
  assign advance  = a_valid && (!a.last_light || !out_valid || !out_stall);
  assign in_stall = a_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a <= in_data;
    end
  end

  // new light inside the inclusive view box outranks any light that is not
  assign cand_high = (a.light_state == lrps_pkg::ST_NEW) &&
                     ($signed(a.pos_x) >= view_min_x) && ($signed(a.pos_x) <= view_max_x) &&
                     ($signed(a.pos_y) >= view_min_y) && ($signed(a.pos_y) <= view_max_y) &&
                     ($signed(a.pos_z) >= view_min_z) && ($signed(a.pos_z) <= view_max_z);

  assign cand.state        = a.light_state;
  assign cand.contribution = a.contribution;
  assign cand.distance     = a.eye_distance;
  assign cand.stamp        = a.lit_stamp;
  assign cand.stage        = a.refine_stage;
  assign cand.high         = cand_high;

  lrps_cmp u_cmp (
    .best  (best),
    .cand  (cand),
    .lower (lower)
  );

  assign take       = (a.light_state != lrps_pkg::ST_FULL) && (!best_valid || lower);
  assign found_next = best_valid || take;
  assign slot_next  = take ? item_count : best_slot;
  assign slot_ext   = {8'd0, slot_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_slot  <= '0;
      best       <= '0;
      item_count <= '0;
    end else if (advance) begin
      if (a.last_light) begin
        best_valid <= 1'b0;
        best_slot  <= '0;
        best       <= '0;
        item_count <= '0;
      end else begin
        if (take) begin
          best_valid <= 1'b1;
          best_slot  <= item_count;
          best       <= cand;
        end
        item_count <= (item_count == LAST_SLOT) ? '0 : item_count + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && a.last_light) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a.last_light) begin
      out_data.found      <= found_next;
      out_data.best_index <= found_next ? slot_ext[7:0] : 8'd0;
    end
  end

endmodule
